// ===== src/bbp_pkg.sv =====
// Shared constants, tables and types for the bearing_between_points block.
// Holds the CORDIC arctangent table and the quadrant control word layout.
// No dependencies.
package bbp_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF      = 24;
    localparam int CORDIC_STAGES_DEF   = 18;
    localparam int ANGLE_FRAC_BITS_DEF = 7;

    // Fixed datapath widths
    localparam int CORDIC_W  = 64;  // x/y vector width
    localparam int SPAN_BITS = 60;  // differences are aligned to this bit
    localparam int Z_W       = 34;  // signed angle accumulator
    localparam int ANG_W     = 33;  // folded angle, full turn = 2^32
    localparam int HEADING_W = 16;  // heading field width
    localparam int DEG_FULL  = 360;
    localparam int DEG_BITS  = 9;   // bits to hold DEG_FULL

    // atan(2^-i) with one full turn = 2^32, rounded to nearest
    localparam logic [31:0] ATAN_TURN [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Quadrant and axis flags that ride along with the CORDIC vector
    typedef struct packed {
        logic same_x;   // start and target share x
        logic same_z;   // start and target share z
        logic z_gt;     // target z above start z
        logic x_lt;     // target x below start x
    } ctl_t;

endpackage

// ===== src/bearing_between_points_top.sv =====
// Bearing from a start point to a target point in the x/z plane, as a
// fully pipelined CORDIC vectoring kernel with quadrant fold and rounding.
// Depends on bbp_pkg.
//
// Pipeline: one register per CORDIC iteration, plus input, fold,
//   multiply and output registers (18 CORDIC stages by default).
// Throughput: one word per cycle; the whole pipeline holds while the
//   output word waits on m_tready.
// Reset: rst_n clears all valid bits asynchronously; data registers are
//   not reset.
module bearing_between_points_top #(
    parameter int COORD_BITS      = bbp_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES   = bbp_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = bbp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // Point pair in
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata, low bit up: start_x, start_z, target_x, target_z, zero pad
    input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Heading out
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata, low bit up: heading
    output logic [bbp_pkg::HEADING_W-1:0] m_tdata
);
    import bbp_pkg::*;

    localparam int N        = CORDIC_STAGES;
    localparam int CB       = COORD_BITS;
    localparam int PRESCALE = SPAN_BITS - COORD_BITS;
    localparam int FULL_W   = DEG_BITS + ANGLE_FRAC_BITS;
    localparam int PROD_W   = ANG_W + FULL_W;
    localparam int H_W      = PROD_W - 31;
    localparam logic [FULL_W-1:0] FULL = FULL_W'(DEG_FULL) << ANGLE_FRAC_BITS;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << 31;

    localparam logic [30:0]      QUARTER_F = 31'h4000_0000;
    localparam logic [ANG_W-1:0] Q1 = 33'h0_4000_0000;
    localparam logic [ANG_W-1:0] Q2 = 33'h0_8000_0000;
    localparam logic [ANG_W-1:0] Q3 = 33'h0_C000_0000;
    localparam logic [ANG_W-1:0] Q4 = 33'h1_0000_0000;

    // Valid bits: 0 input, 1..N CORDIC, N+1 fold, N+2 multiply, N+3 output
    logic [N+3:0] vld_reg;
    logic         adv;

    // Pipeline payload
    logic        [CORDIC_W-1:0] x_reg   [0:N];
    logic signed [CORDIC_W-1:0] y_reg   [0:N];
    logic signed [Z_W-1:0]      z_reg   [0:N];
    ctl_t                       ctl_reg [0:N];
    logic [ANG_W-1:0]           ang_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [FULL_W-1:0]          hd_reg;

    // Input unpack and differences
    logic signed [CB-1:0] start_x, start_z, target_x, target_z;
    logic signed [CB:0]   dx, dz, dx_abs, dz_abs;
    logic [CORDIC_W-1:0]  x0_next, y0_next;
    ctl_t                 ctl0_next;

    // Advance the whole pipe whenever the output slot is free or taken
    assign adv      = !vld_reg[N+3] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[N+3];

    assign start_x  = s_tdata[CB-1:0];
    assign start_z  = s_tdata[2*CB-1:CB];
    assign target_x = s_tdata[3*CB-1:2*CB];
    assign target_z = s_tdata[4*CB-1:3*CB];

    // Form absolute differences and quadrant flags
    always_comb
    begin
        dx     = {target_x[CB-1], target_x} - {start_x[CB-1], start_x};
        dz     = {target_z[CB-1], target_z} - {start_z[CB-1], start_z};
        dx_abs = dx[CB] ? -dx : dx;
        dz_abs = dz[CB] ? -dz : dz;
        x0_next = CORDIC_W'(dz_abs[CB-1:0]) << PRESCALE;
        y0_next = CORDIC_W'(dx_abs[CB-1:0]) << PRESCALE;
        ctl0_next.same_x = (dx == '0);
        ctl0_next.same_z = (dz == '0);
        ctl0_next.z_gt   = !dz[CB] && (dz != '0);
        ctl0_next.x_lt   = dx[CB];
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N+2:0], s_tvalid};
        end
    end

    // Load the input stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= '0;
            ctl_reg[0] <= ctl0_next;
        end
    end

    // One CORDIC vectoring iteration per stage
    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        logic        [CORDIC_W-1:0] xs, x_next;
        logic signed [CORDIC_W-1:0] ys, y_next;
        logic signed [Z_W-1:0]      at, z_next;

        assign xs = x_reg[k] >> k;
        assign ys = y_reg[k] >>> k;
        assign at = Z_W'(ATAN_TURN[k]);

        // Rotate toward the x axis by the sign of y
        always_comb
        begin
            if (!y_reg[k][CORDIC_W-1])
            begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + at;
            end
            else
            begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k+1]   <= x_next;
                y_reg[k+1]   <= y_next;
                z_reg[k+1]   <= z_next;
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    // Clamp the CORDIC angle and fold it into the quadrant
    logic [30:0]      f_ang;
    logic [ANG_W-1:0] f_ext, ang_next;
    ctl_t             cf;

    always_comb
    begin
        cf = ctl_reg[N];
        if (z_reg[N][Z_W-1])
            f_ang = '0;
        else if (z_reg[N] > $signed(Z_W'(QUARTER_F)))
            f_ang = QUARTER_F;
        else
            f_ang = z_reg[N][30:0];
        f_ext = ANG_W'(f_ang);

        if (cf.same_x)
            ang_next = cf.z_gt ? Q2 : '0;
        else if (cf.same_z)
            ang_next = cf.x_lt ? Q3 : Q1;
        else if (cf.z_gt)
            ang_next = cf.x_lt ? Q2 + f_ext : Q2 - f_ext;
        else
            ang_next = cf.x_lt ? Q4 - f_ext : f_ext;
    end

    // Scale to output units, then round and wrap the full circle
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W:0]   rnd_sum;
    logic [H_W-1:0]    h_wide, h_wrap;
    logic [FULL_W-1:0] hd_next;

    always_comb
    begin
        prod_next = PROD_W'(ang_reg) * PROD_W'(FULL);
        rnd_sum   = (PROD_W + 1)'(prod_reg) + ROUND_HALF;
        h_wide    = rnd_sum[PROD_W:32];
        h_wrap    = (h_wide >= H_W'(FULL)) ? h_wide - H_W'(FULL) : h_wide;
        hd_next   = h_wrap[FULL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg  <= ang_next;
            prod_reg <= prod_next;
            hd_reg   <= hd_next;
        end
    end

    // Fit the heading to the output field
    if (FULL_W >= HEADING_W)
    begin : g_trunc
        assign m_tdata = hd_reg[HEADING_W-1:0];
    end
    else
    begin : g_ext
        assign m_tdata = {{(HEADING_W - FULL_W){1'b0}}, hd_reg};
    end

    // A waiting output word must block new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output word stalled");

    // Folded angle never exceeds one full turn
    a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N+1] |-> ang_reg <= Q4)
        else $error("folded angle out of range");

    // Wrapped heading stays below the full circle
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> hd_reg < FULL)
        else $error("heading not wrapped below full circle");

    // CORDIC x magnitude keeps its sign bit clear after the last stage
    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N] |-> !x_reg[N][CORDIC_W-1])
        else $error("CORDIC x overflowed");

endmodule

// ===== dv/tb_bearing_between_points_top.sv =====
// Self-checking testbench for bearing_between_points_top: streams point pairs
// in, predicts each heading with a bit-true CORDIC model, and checks the output.
// Depends on bbp_pkg and the bearing_between_points_top RTL.
module tb_bearing_between_points_top;

    import bbp_pkg::*;

    localparam int CW       = COORD_BITS_DEF;
    localparam int STAGES   = CORDIC_STAGES_DEF;
    localparam int FRAC     = ANGLE_FRAC_BITS_DEF;
    localparam int PRESCALE = SPAN_BITS - CW;
    localparam int IN_W     = ((4 * CW + 7) / 8) * 8;
    localparam longint unsigned FULL_HEADING = longint'(DEG_FULL) << FRAC;
    localparam longint QUARTER  = 64'd1 << 30;
    localparam int LATENCY      = STAGES + 3;
    localparam int RANDOM_PAIRS = 2000;
    localparam int TAIL_PAIRS   = 300;   // no idling once this few remain
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [HEADING_W-1:0] m_tdata;

    logic [IN_W-1:0] pair_queue [$];        // point pairs waiting to be sent
    logic [HEADING_W-1:0] heading_queue [$]; // predicted headings in flight

    int cycles = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int src_mode = 0;
    int snk_mode = 0;
    int pairs_sent = 0;
    int headings_seen = 0;
    int axis_headings = 0;
    int directed_pairs = 0;
    int mismatches = 0;

    bearing_between_points_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 clk = ~clk;

    // Pack one point pair, start_x in the low bits
    function automatic logic [IN_W-1:0] pack_pair(coord_t sx, coord_t sz, coord_t tx, coord_t tz);
        logic [IN_W-1:0] w;
        w = '0;
        w[4*CW-1:0] = {tz, tx, sz, sx};
        return w;
    endfunction

    // Bit-true heading of a packed point pair
    function automatic logic [HEADING_W-1:0] heading_of(logic [IN_W-1:0] w);
        coord_t sx, sz, tx, tz;
        longint dx, dz, ang, f;
        logic [63:0] vx, vy, xs, ys;
        longint unsigned h;
        sx = w[CW-1:0];
        sz = w[2*CW-1:CW];
        tx = w[3*CW-1:2*CW];
        tz = w[4*CW-1:3*CW];
        if (sx == tx) begin
            ang = (tz > sz) ? 2 * QUARTER : 0;
        end
        else if (sz == tz) begin
            ang = (tx > sx) ? QUARTER : 3 * QUARTER;
        end
        else begin
            dx = longint'(tx) - longint'(sx);
            dz = longint'(tz) - longint'(sz);
            if (dx < 0) dx = -dx;
            if (dz < 0) dz = -dz;
            // vectoring CORDIC on (|dz|, |dx|), first quadrant
            vx = 64'(dz) << PRESCALE;
            vy = 64'(dx) << PRESCALE;
            f = 0;
            for (int i = 0; i < STAGES && i < 32; i++) begin
                xs = vx >> i;
                ys = $unsigned($signed(vy) >>> i);
                if (!vy[63]) begin
                    vx = vx + ys;
                    vy = vy - xs;
                    f = f + longint'(ATAN_TURN[i]);
                end
                else begin
                    vx = vx - ys;
                    vy = vy + xs;
                    f = f - longint'(ATAN_TURN[i]);
                end
            end
            if (f < 0) f = 0;
            if (f > QUARTER) f = QUARTER;
            // fold into the target's quadrant
            if (tz > sz)
                ang = (tx < sx) ? 2 * QUARTER + f : 2 * QUARTER - f;
            else
                ang = (tx < sx) ? 4 * QUARTER - f : f;
        end
        h = (longint'(ang) * FULL_HEADING + 64'h8000_0000) >> 32;
        if (h >= FULL_HEADING)
            h = h - FULL_HEADING;
        return h[HEADING_W-1:0];
    endfunction

    task automatic add_pair(coord_t sx, coord_t sz, coord_t tx, coord_t tz);
        pair_queue.push_back(pack_pair(sx, sz, tx, tz));
    endtask

    // Cycle count and random idling modes for source and sink
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles % 256 == 0) begin
            src_mode <= $urandom_range(0, 2);
            snk_mode <= $urandom_range(0, 2);
        end
    end

    // Source driver: record accepted words, then present the next one
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                heading_queue.push_back(heading_of(s_tdata));
                pairs_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pair_queue.size() > TAIL_PAIRS && src_mode != 0 &&
                         $urandom_range(0, src_mode == 1 ? 7 : 1) == 0) begin
                    src_gap = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end
                else if (pair_queue.size() > 0) begin
                    s_tdata  <= pair_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink monitor: check each accepted heading, then drive back-pressure
    always @(posedge clk or negedge rst_n) begin
        logic [HEADING_W-1:0] want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                headings_seen++;
                if (m_tdata % (90 << FRAC) == 0)
                    axis_headings++;
                if (heading_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: unexpected heading word %0d at cycle %0d",
                                 m_tdata, cycles);
                end
                else begin
                    want = heading_queue.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR: heading mismatch at cycle %0d: expected %0d, got %0d",
                                     cycles, want, m_tdata);
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else if (pair_queue.size() > TAIL_PAIRS && snk_mode != 0 &&
                     $urandom_range(0, snk_mode == 1 ? 7 : 1) == 0) begin
                snk_gap = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus, end of run and verdict
    initial begin
        coord_t sx, sz, tx, tz;
        int kind;
        bit timed_out;

        // axis cases and identical points
        add_pair(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0));
        add_pair(coord_t'(5), coord_t'(-7), coord_t'(5), coord_t'(100));
        add_pair(coord_t'(5), coord_t'(100), coord_t'(5), coord_t'(-7));
        add_pair(C_MIN, coord_t'(3), C_MAX, coord_t'(3));
        add_pair(C_MAX, coord_t'(3), C_MIN, coord_t'(3));
        add_pair(C_MAX, C_MAX, C_MAX, C_MAX);
        // widest differences in all four quadrants
        add_pair(C_MIN, C_MIN, C_MAX, C_MAX);
        add_pair(C_MAX, C_MAX, C_MIN, C_MIN);
        add_pair(C_MIN, C_MAX, C_MAX, C_MIN);
        add_pair(C_MAX, C_MIN, C_MIN, C_MAX);
        // near-axis angles: rounds up to a full circle, clamps near a quarter
        add_pair(coord_t'(0), C_MAX, coord_t'(-1), C_MIN);
        add_pair(coord_t'(0), C_MIN, coord_t'(1), C_MAX);
        add_pair(C_MIN, coord_t'(0), C_MAX, coord_t'(1));
        add_pair(C_MAX, coord_t'(0), C_MIN, coord_t'(-1));
        add_pair(coord_t'(0), C_MAX, coord_t'(1), C_MIN);
        // diagonals and unit steps
        add_pair(coord_t'(10), coord_t'(10), coord_t'(20), coord_t'(20));
        add_pair(coord_t'(10), coord_t'(10), coord_t'(0), coord_t'(0));
        add_pair(coord_t'(-1), coord_t'(-1), coord_t'(0), coord_t'(0));
        add_pair(coord_t'(0), coord_t'(0), coord_t'(-1), coord_t'(1));
        add_pair(24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555);
        add_pair(24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA);
        directed_pairs = pair_queue.size();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            kind = $urandom_range(0, 9);
            sx = coord_t'($urandom());
            sz = coord_t'($urandom());
            tx = coord_t'($urandom());
            tz = coord_t'($urandom());
            case (kind)
                4, 5: begin
                    // short hop from a random start
                    tx = sx + coord_t'($urandom_range(0, 600) - 300);
                    tz = sz + coord_t'($urandom_range(0, 600) - 300);
                end
                6: tx = sx;
                7: tz = sz;
                8: begin
                    tx = sx;
                    tz = sz;
                end
                9: begin
                    sx = $urandom_range(0, 1) ? C_MIN : C_MAX;
                    tz = $urandom_range(0, 1) ? C_MIN : C_MAX;
                end
                default: ;
            endcase
            add_pair(sx, sz, tx, tz);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: everything sent and every heading back
        while ((pair_queue.size() > 0 || s_tvalid || heading_queue.size() > 0) &&
               cycles < CYCLE_LIMIT)
            @(negedge clk);
        timed_out = (cycles >= CYCLE_LIMIT);

        if (timed_out) begin
            $display("ERROR: run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("Test completed with failures");
        end
        else begin
            repeat (LATENCY + 10) @(negedge clk);
            if (heading_queue.size() != 0) begin
                mismatches += heading_queue.size();
                $display("ERROR: %0d headings never arrived", heading_queue.size());
            end
            $display("Sent %0d point pairs (%0d directed), checked %0d headings, %0d on an axis.",
                     pairs_sent, directed_pairs, headings_seen, axis_headings);
            $display("Mismatches: %0d over %0d cycles.", mismatches, cycles);
            if (mismatches == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bbp_pkg.sv
src/bearing_between_points_top.sv
dv/tb_bearing_between_points_top.sv
